// ===== src/rld_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the run-length deque
// no dependencies
package rld_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 32;

  localparam int MODE_W     = 3;
  localparam int IN_VALUE_W = 32;
  localparam int STATUS_W   = 2;
  localparam int LEN_W      = 11;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [MODE_W-1:0] {
    M_PUSH_BACK   = 3'd0,
    M_PUSH_FRONT  = 3'd1,
    M_POP_BACK    = 3'd2,
    M_POP_FRONT   = 3'd3,
    M_QUERY_LEFT  = 3'd4,
    M_QUERY_RIGHT = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUN_LEN   = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic stall;
  } dp_stat_t;

endpackage

// ===== src/rld_ctrl.sv =====
`timescale 1ns / 1ps
// controller for the run-length deque: capture then update
// depends on rld_pkg
module rld_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rld_pkg::dp_stat_t stat,
  output rld_pkg::ctrl_cmd_t cmd
);
  import rld_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_EXEC: begin
        cmd.commit = !stat.stall;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/rld_dp.sv =====
`timescale 1ns / 1ps
// datapath for the run-length deque: value and run rings, pointers, result register
// depends on rld_pkg
module rld_dp #(
  parameter int DEPTH      = rld_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = rld_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rld_pkg::ctrl_cmd_t                  cmd,
  output rld_pkg::dp_stat_t                   stat,
  input  logic [rld_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [rld_pkg::IN_VALUE_W-1:0] in_value,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [rld_pkg::STATUS_W-1:0]        out_status,
  output logic [rld_pkg::LEN_W-1:0]           out_run_length
);
  import rld_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [CW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_A : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_A) ? '0 : p + AW'(1);
  endfunction

  logic [VALUE_BITS-1:0] vmem [DEPTH];
  logic [LEN_W-1:0]      rmem [DEPTH];

  logic [AW-1:0] vhead_r, vhead_nxt, rhead_r, rhead_nxt;
  logic [CW-1:0] vcount_r, vcount_nxt, rtotal_r, rtotal_nxt;
  logic [MODE_W-1:0]     mode_r;
  logic [VALUE_BITS-1:0] vin_r;
  logic [VALUE_BITS-1:0] vrd_r;
  logic [LEN_W-1:0]      rrd_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [LEN_W-1:0]      out_len_r;

  logic [AW-1:0] vtail, vback, vhead_dec, vhead_inc;
  logic [AW-1:0] rtail, rback, rhead_dec, rhead_inc;
  logic [AW-1:0] vraddr, rraddr, vwaddr, rwaddr;
  logic          vwe, rwe;
  logic [LEN_W-1:0] rwdata, rinc, rdec;
  logic          full, match, res;
  status_t       res_status;
  logic [LEN_W-1:0] res_len;

  assign vtail     = wrap_add(vhead_r, vcount_r);
  assign vback     = ptr_dec(vtail);
  assign vhead_dec = ptr_dec(vhead_r);
  assign vhead_inc = ptr_inc(vhead_r);
  assign rtail     = wrap_add(rhead_r, rtotal_r);
  assign rback     = ptr_dec(rtail);
  assign rhead_dec = ptr_dec(rhead_r);
  assign rhead_inc = ptr_inc(rhead_r);

  // read addresses follow the incoming mode
  assign vraddr = (in_mode == M_PUSH_BACK) ? vback : vhead_r;
  assign rraddr = (in_mode == M_PUSH_BACK || in_mode == M_POP_BACK ||
                   in_mode == M_QUERY_RIGHT) ? rback : rhead_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      vin_r  <= VALUE_BITS'(in_value);
      vrd_r  <= vmem[vraddr];
      rrd_r  <= rmem[rraddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && vwe) begin
      vmem[vwaddr] <= vin_r;
    end
    if (cmd.commit && rwe) begin
      rmem[rwaddr] <= rwdata;
    end
  end

  assign full  = (vcount_r == DEPTH_C);
  assign match = (vcount_r != '0) && (rtotal_r != '0) && (vrd_r == vin_r);
  assign rinc  = rrd_r + LEN_W'(1);
  assign rdec  = rrd_r - LEN_W'(1);

  always_comb begin
    vwe        = 1'b0;
    rwe        = 1'b0;
    vwaddr     = vtail;
    rwaddr     = rtail;
    rwdata     = LEN_W'(1);
    vhead_nxt  = vhead_r;
    rhead_nxt  = rhead_r;
    vcount_nxt = vcount_r;
    rtotal_nxt = rtotal_r;
    res        = 1'b0;
    res_status = ST_RUN_LEN;
    res_len    = '0;
    unique case (mode_r)
      M_PUSH_BACK, M_PUSH_FRONT: begin
        if (full) begin
          res        = 1'b1;
          res_status = ST_PUSH_FULL;
        end else begin
          vwe        = 1'b1;
          rwe        = 1'b1;
          vcount_nxt = vcount_r + CW'(1);
          if (mode_r == M_PUSH_BACK) begin
            vwaddr = vtail;
            if (match) begin
              rwaddr = rback;
              rwdata = rinc;
            end else begin
              rwaddr     = rtail;
              rtotal_nxt = rtotal_r + CW'(1);
            end
          end else begin
            vwaddr    = vhead_dec;
            vhead_nxt = vhead_dec;
            if (match) begin
              rwaddr = rhead_r;
              rwdata = rinc;
            end else begin
              rwaddr     = rhead_dec;
              rhead_nxt  = rhead_dec;
              rtotal_nxt = rtotal_r + CW'(1);
            end
          end
        end
      end
      M_POP_BACK, M_POP_FRONT: begin
        if (vcount_r == '0) begin
          res        = 1'b1;
          res_status = ST_POP_EMPTY;
        end else begin
          vcount_nxt = vcount_r - CW'(1);
          if (mode_r == M_POP_FRONT) begin
            vhead_nxt = vhead_inc;
          end
          if (rtotal_r != '0) begin
            rwe    = 1'b1;
            rwaddr = (mode_r == M_POP_BACK) ? rback : rhead_r;
            rwdata = rdec;
            if (rdec == '0) begin
              rtotal_nxt = rtotal_r - CW'(1);
              if (mode_r == M_POP_FRONT) begin
                rhead_nxt = rhead_inc;
              end
            end
          end
        end
      end
      M_QUERY_LEFT, M_QUERY_RIGHT: begin
        res     = 1'b1;
        res_len = (rtotal_r == '0) ? '0 : rrd_r;
      end
      default: ;
    endcase
  end

  assign stat.stall = res && out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vhead_r     <= '0;
      vcount_r    <= '0;
      rhead_r     <= '0;
      rtotal_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        vhead_r  <= vhead_nxt;
        vcount_r <= vcount_nxt;
        rhead_r  <= rhead_nxt;
        rtotal_r <= rtotal_nxt;
      end
      if (cmd.commit && res) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && res) begin
      out_status_r <= res_status;
      out_len_r    <= res_len;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_status     = out_status_r;
  assign out_run_length = out_len_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= DEPTH_C) else $error("value count beyond capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vhead_r <= LAST_A) && (rhead_r <= LAST_A)) else $error("ring head out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && res |-> !(out_valid_r && !out_tready))
    else $error("pending result overwritten");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && full && (mode_r == M_PUSH_BACK || mode_r == M_PUSH_FRONT)
    |=> $stable(vcount_r) && $stable(rtotal_r)) else $error("dropped push changed state");
`endif

endmodule

// ===== src/run_length_deque_top.sv =====
`timescale 1ns / 1ps
// channel   | dir | item fields (tdata, lowest bit first)
// in_*      | in  | mode [2:0], value [34:3] signed, zero pad [39:35]
// out_*     | out | status [1:0], run_length [12:2], zero pad [15:13]
// each item is handled in a capture step, which reads the end entries of both rings
// into registers, and then an update step for the rings and pointers
// a result waiting in the output register holds the update cycle only
// when the new item also has a result
// reset empties the deque at once; the rings need no clearing pass
// top level of the run-length deque; depends on rld_pkg, rld_ctrl, rld_dp
module run_length_deque_top #(
  parameter int DEPTH      = rld_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = rld_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rld_pkg::IN_DATA_W-1:0]     in_tdata,   // mode, value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rld_pkg::OUT_DATA_W-1:0]    out_tdata   // status, run_length
);
  import rld_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    run_length;

  rld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rld_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_mode        (in_tdata[MODE_W-1:0]),
    .in_value       (in_tdata[MODE_W+IN_VALUE_W-1:MODE_W]),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_status     (status),
    .out_run_length (run_length)
  );

  assign out_tdata = OUT_DATA_W'({run_length, status});

endmodule

// ===== verif/tb_run_length_deque_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for run_length_deque_top: a queued stream driver, a stalling sink
// and a shadow run-length deque that predicts every answer; depends on rld_pkg and the rtl
module tb_run_length_deque_top;
  import rld_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct {
    status_t              status;
    logic [LEN_W-1:0]     run_length;
  } deque_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;     // mode, value
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // status, run_length

  run_length_deque_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow deque
  logic [IN_VALUE_W-1:0] value_store [DEPTH];
  logic [LEN_W-1:0]      run_store [DEPTH];
  int                    value_first = 0;
  int                    value_fill = 0;
  int                    run_first = 0;
  int                    run_fill = 0;

  logic [IN_DATA_W-1:0]  pending_items [$];
  deque_result_t         expected_results [$];
  deque_result_t         oldest_answer;
  int                    failures = 0;

  // stimulus shaping
  int                    gen_fill = 0;
  logic [IN_VALUE_W-1:0] last_pushed = '0;

  function automatic logic [IN_DATA_W-1:0] pack_item(logic [MODE_W-1:0] mode,
                                                     logic [IN_VALUE_W-1:0] value);
    return {{(IN_DATA_W - MODE_W - IN_VALUE_W){1'b0}}, value, mode};
  endfunction

  task automatic expect_result(deque_result_t res);
    expected_results.insert(expected_results.size(), res);
  endtask

  task automatic add_item(logic [MODE_W-1:0] mode, logic [IN_VALUE_W-1:0] value);
    pending_items.insert(pending_items.size(), pack_item(mode, value));
    if (mode == M_PUSH_BACK || mode == M_PUSH_FRONT) begin
      last_pushed = value;
      if (gen_fill < DEPTH) gen_fill++;
    end else if (mode == M_POP_BACK || mode == M_POP_FRONT) begin
      if (gen_fill > 0) gen_fill--;
    end
  endtask

  function automatic logic [IN_VALUE_W-1:0] push_value();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return last_pushed;
      4:          return 32'h8000_0000;
      5:          return 32'h7fff_ffff;
      6:          return $urandom_range(0, 3);
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(int push_w, int pop_w, int query_w);
    int roll;
    roll = $urandom_range(0, push_w + pop_w + query_w + 3);
    if (roll < push_w) return ($urandom_range(0, 1) != 0) ? M_PUSH_BACK : M_PUSH_FRONT;
    if (roll < push_w + pop_w) return ($urandom_range(0, 1) != 0) ? M_POP_BACK : M_POP_FRONT;
    if (roll < push_w + pop_w + query_w)
      return ($urandom_range(0, 1) != 0) ? M_QUERY_LEFT : M_QUERY_RIGHT;
    return ($urandom_range(0, 1) != 0) ? MODE_SPARE_6 : MODE_SPARE_7;
  endfunction

  task automatic add_random(int push_w, int pop_w, int query_w);
    logic [MODE_W-1:0] mode;
    mode = pick_mode(push_w, pop_w, query_w);
    if (mode == M_PUSH_BACK || mode == M_PUSH_FRONT) add_item(mode, push_value());
    else add_item(mode, $urandom);
  endtask

  task automatic apply_deque_op(input logic [IN_DATA_W-1:0] item);
    logic [MODE_W-1:0]     op;
    logic [IN_VALUE_W-1:0] v;
    int                    value_back;
    int                    run_back;
    int                    idx;
    deque_result_t         res;
    op = item[MODE_W-1:0];
    v = item[MODE_W +: IN_VALUE_W];
    value_back = (value_first + value_fill + DEPTH - 1) % DEPTH;
    run_back = (run_first + run_fill + DEPTH - 1) % DEPTH;
    res.run_length = '0;
    case (op)
      M_PUSH_BACK, M_PUSH_FRONT: begin
        if (value_fill >= DEPTH) begin
          res.status = ST_PUSH_FULL;
          expect_result(res);
        end else begin
          if (op == M_PUSH_BACK) begin
            if (value_fill > 0 && run_fill > 0 && value_store[value_back] == v) begin
              run_store[run_back] = run_store[run_back] + 1'b1;
            end else begin
              run_store[(run_first + run_fill) % DEPTH] = 1;
              run_fill++;
            end
            value_store[(value_first + value_fill) % DEPTH] = v;
          end else begin
            if (value_fill > 0 && run_fill > 0 && value_store[value_first] == v) begin
              run_store[run_first] = run_store[run_first] + 1'b1;
            end else begin
              run_first = (run_first + DEPTH - 1) % DEPTH;
              run_store[run_first] = 1;
              run_fill++;
            end
            value_first = (value_first + DEPTH - 1) % DEPTH;
            value_store[value_first] = v;
          end
          value_fill++;
        end
      end
      M_POP_BACK, M_POP_FRONT: begin
        if (value_fill == 0) begin
          res.status = ST_POP_EMPTY;
          expect_result(res);
        end else begin
          value_fill--;
          if (op == M_POP_FRONT) value_first = (value_first + 1) % DEPTH;
          if (run_fill > 0) begin
            idx = (op == M_POP_BACK) ? run_back : run_first;
            run_store[idx] = run_store[idx] - 1'b1;
            if (run_store[idx] == 0) begin
              run_fill--;
              if (op == M_POP_FRONT) run_first = (run_first + 1) % DEPTH;
            end
          end
        end
      end
      M_QUERY_LEFT, M_QUERY_RIGHT: begin
        res.status = ST_RUN_LEN;
        if (run_fill > 0) res.run_length = run_store[(op == M_QUERY_LEFT) ? run_first : run_back];
        expect_result(res);
      end
      default: begin
      end
    endcase
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_deque_op(in_tdata);
        pending_items.delete(0);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_items[0];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink: rotating stall pattern, reloaded periodically with a random pattern
  logic [31:0] stall_pat = '1;
  int          stall_tick = 0;

  always @(posedge clk) begin
    out_tready <= stall_pat[0];
    stall_tick <= stall_tick + 1;
    if (stall_tick % 32 == 31) begin
      case ($urandom_range(0, 3))
        0:       stall_pat <= '1;
        1:       stall_pat <= $urandom | 32'd1;
        default: stall_pat <= $urandom | $urandom | 32'd1;
      endcase
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[31:1]};
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item: tdata %h", out_tdata);
        failures++;
      end else begin
        oldest_answer = expected_results[0];
        expected_results.delete(0);
        if (out_tdata[STATUS_W-1:0] !== oldest_answer.status) begin
          $error("status: expected %0d, actual %0d", oldest_answer.status,
                 out_tdata[STATUS_W-1:0]);
          failures++;
        end
        if (out_tdata[STATUS_W +: LEN_W] !== oldest_answer.run_length) begin
          $error("run_length: expected %0d, actual %0d", oldest_answer.run_length,
                 out_tdata[STATUS_W +: LEN_W]);
          failures++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[run_length_deque_top] ERROR");
    $finish;
  end

  initial begin
    logic [IN_VALUE_W-1:0] fill_value;
    // empty deque corner cases and ignored codes
    add_item(M_QUERY_LEFT, $urandom);
    add_item(M_QUERY_RIGHT, $urandom);
    add_item(M_POP_BACK, $urandom);
    add_item(M_POP_FRONT, $urandom);
    add_item(MODE_SPARE_6, $urandom);
    add_item(MODE_SPARE_7, $urandom);
    // runs at both ends with extreme values
    add_item(M_PUSH_BACK, 32'h7fff_ffff);
    add_item(M_PUSH_BACK, 32'h7fff_ffff);
    add_item(M_PUSH_FRONT, 32'h8000_0000);
    add_item(M_PUSH_FRONT, 32'h8000_0000);
    add_item(M_PUSH_BACK, 32'hffff_ffff);
    add_item(M_QUERY_LEFT, $urandom);
    add_item(M_QUERY_RIGHT, $urandom);
    add_item(M_PUSH_FRONT, 32'h0000_0000);
    add_item(M_POP_BACK, $urandom);
    add_item(M_QUERY_RIGHT, $urandom);
    add_item(M_POP_FRONT, $urandom);
    add_item(M_QUERY_LEFT, $urandom);
    add_item(M_POP_FRONT, $urandom);
    add_item(M_POP_FRONT, $urandom);
    add_item(M_QUERY_LEFT, $urandom);
    add_item(M_POP_BACK, $urandom);
    add_item(M_POP_BACK, $urandom);
    add_item(M_POP_FRONT, $urandom);
    add_item(M_QUERY_RIGHT, $urandom);

    // small deque, frequent empty pops
    repeat (40) add_random(50, 30, 16);

    // fill to capacity with one value, then push into a full deque
    fill_value = $urandom;
    while (gen_fill < DEPTH) begin
      if ($urandom_range(0, 39) == 0) add_item(pick_mode(0, 0, 1), $urandom);
      else add_item(($urandom_range(0, 1) != 0) ? M_PUSH_BACK : M_PUSH_FRONT, fill_value);
    end
    add_item(M_QUERY_LEFT, $urandom);
    add_item(M_QUERY_RIGHT, $urandom);
    add_item(M_PUSH_BACK, fill_value);
    add_item(M_PUSH_FRONT, ~fill_value);
    add_item(M_PUSH_BACK, $urandom);

    // mixed traffic near capacity
    repeat (40) add_random(40, 35, 20);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("[run_length_deque_top] OK");
    end else begin
      $display("[run_length_deque_top] ERROR");
    end
    $finish;
  end

endmodule
